[sv/fba_pkg.sv]
`default_nettype none

package fba_pkg;

    localparam int FRAME_W         = 21;
    localparam int ADDR_W          = 32;
    localparam int WORD_W          = 32;
    localparam int BIT_W           = 5;
    localparam int PAGE_SHIFT      = 12;
    localparam int FRAME_COUNT_DEF = 1048576;
    localparam int CFG_IDX_W       = 1;

    localparam logic [FRAME_W-1:0] LOW_END_RST = FRAME_W'(229376);
    localparam logic [FRAME_W-1:0] MEM_END_RST = FRAME_W'(1048576);

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ZONE_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_END   = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_TEST    = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_ALLOC_RD,
        ST_ALLOC_SEG,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_TEST_RD,
        ST_TEST_BIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic                high_zone;
        logic [ADDR_W-1:0]   byte_address;
        logic [FRAME_W-2:0]  frame_number;
        logic [FRAME_W-1:0]  page_count;
        logic [ADDR_W-1:0]   length_bytes;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic              found;
        logic              frame_used;
    } t_rsp;

    // bits below off set; off of WORD_W or more gives all ones
    function automatic logic [WORD_W-1:0] mask_below(input logic [BIT_W:0] off);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return ~(ones << off);
    endfunction

endpackage

`default_nettype wire

[sv/fba_ram.sv]
`default_nettype none

module fba_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wa,
    input  wire logic [DATA_W-1:0]        i_wd,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_ra,
    output logic      [DATA_W-1:0]        o_rd
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end

endmodule

`default_nettype wire

[sv/frame_bitmap_allocator.sv]
// Page-frame allocator over a one-bit-per-frame used map held in RAM,
// 32 frames to a word.
// Request channel (i_in_valid / o_in_stall, i_in_data) takes one transaction
// at a time: allocate, free, reserve or test. Each produces exactly one
// response transaction on o_out_valid / i_out_stall, o_out_data.
// Allocate scans the map for a free run and marks a run it finds used; free
// and reserve rewrite each word touched; test reads one word. The next request
// is taken in the cycle after the previous response is loaded into the
// output register.
// A response is registered; a new request is taken while it waits, and the
// following response waits in the block until the receiver lifts i_out_stall.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) go to the
// zone limit registers. The user must see that they are made only while the
// block is idle; the block itself does not enforce this.
// After reset the map is swept to all free, one word a cycle, with the
// request channel stalled.
`default_nettype none

module frame_bitmap_allocator #(
    parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire fba_pkg::t_req                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fba_pkg::t_rsp                        o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fba_pkg::FRAME_W-1:0]     i_cfg_data
);

    import fba_pkg::*;

    localparam int DEPTH = (FRAME_COUNT + WORD_W - 1) / WORD_W;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(FRAME_COUNT);
    localparam logic [AW-1:0]      LAST_WORD   = AW'(DEPTH - 1);

    t_state             r_state, n_state;
    logic [FRAME_W-1:0] r_pos, n_pos;
    logic [FRAME_W-1:0] r_stop, n_stop;
    logic [FRAME_W-1:0] r_start, n_start;
    logic [FRAME_W-1:0] r_run, n_run;
    logic [FRAME_W-1:0] r_low_end, n_low_end;
    logic [FRAME_W-1:0] r_mem_end, n_mem_end;
    logic               r_out_valid, n_out_valid;
    t_req               r_req, n_req;
    t_rsp               r_res, n_res;
    t_rsp               r_out, n_out;

    logic               ram_we;
    logic [AW-1:0]      ram_wa;
    logic [WORD_W-1:0]  ram_wd;
    logic               ram_re;
    logic [AW-1:0]      ram_ra;
    logic [WORD_W-1:0]  ram_rd;

    fba_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (DEPTH)
    ) u_map (
        .i_clk (i_clk),
        .i_we  (ram_we),
        .i_wa  (ram_wa),
        .i_wd  (ram_wd),
        .i_re  (ram_re),
        .i_ra  (ram_ra),
        .o_rd  (ram_rd)
    );

    // shared segment unit
    logic [FRAME_W-1:0] wbase;
    logic [BIT_W-1:0]   bit_off;
    logic [FRAME_W-1:0] hi_off;
    logic [BIT_W:0]     hi_sat;
    logic [WORD_W-1:0]  upper_mask;
    logic [WORD_W-1:0]  lower_mask;
    logic [WORD_W-1:0]  cand;
    logic [BIT_W-1:0]   first_used;
    logic [BIT_W:0]     seg_len;
    logic [FRAME_W:0]   run_sum;
    logic               seg_hit;
    logic [FRAME_W-1:0] seg_next;

    // setup arithmetic
    logic [FRAME_W-1:0] low_end_c, mem_end_c;
    logic [FRAME_W-1:0] zone_lo, zone_hi;
    logic [ADDR_W:0]    len_round;
    logic [FRAME_W-1:0] mk_first, mk_count;
    logic [FRAME_W:0]   mk_stop_raw;
    logic [FRAME_W-1:0] mk_stop;
    logic [FRAME_W-1:0] probe_frame;

    always_comb begin
        wbase      = {r_pos[FRAME_W-1:BIT_W], {BIT_W{1'b0}}};
        bit_off    = r_pos[BIT_W-1:0];
        hi_off     = r_stop - wbase;
        hi_sat     = (|hi_off[FRAME_W-1:BIT_W]) ? (BIT_W+1)'(WORD_W)
                                                : {1'b0, hi_off[BIT_W-1:0]};
        upper_mask = mask_below(hi_sat);
        lower_mask = ~mask_below({1'b0, bit_off});
        cand       = (ram_rd | ~upper_mask) & lower_mask;
        first_used = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                first_used = BIT_W'(i);
            end
        end
        seg_len  = (cand == '0) ? ((BIT_W+1)'(WORD_W) - {1'b0, bit_off})
                                : ({1'b0, first_used} - {1'b0, bit_off});
        run_sum  = {1'b0, r_run} + (FRAME_W+1)'(seg_len);
        seg_hit  = run_sum >= {1'b0, r_req.page_count};
        seg_next = (cand == '0) ? (wbase + FRAME_W'(WORD_W))
                                : (wbase + FRAME_W'(first_used) + FRAME_W'(1));
    end

    always_comb begin
        low_end_c = (r_low_end > FRAME_LIMIT) ? FRAME_LIMIT : r_low_end;
        mem_end_c = (r_mem_end > FRAME_LIMIT) ? FRAME_LIMIT : r_mem_end;
        zone_lo   = r_req.high_zone ? low_end_c : '0;
        zone_hi   = r_req.high_zone ? mem_end_c : low_end_c;
        len_round = {1'b0, r_req.length_bytes} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
        if (r_req.opcode == OP_FREE) begin
            mk_first = {1'b0, r_req.frame_number};
            mk_count = r_req.page_count;
        end else begin
            mk_first = {1'b0, r_req.byte_address[ADDR_W-1:PAGE_SHIFT]};
            mk_count = len_round[ADDR_W:PAGE_SHIFT];
        end
        mk_stop_raw = {1'b0, mk_first} + {1'b0, mk_count};
        mk_stop     = (mk_stop_raw > {1'b0, FRAME_LIMIT}) ? FRAME_LIMIT
                                                          : mk_stop_raw[FRAME_W-1:0];
        probe_frame = {1'b0, r_req.byte_address[ADDR_W-1:PAGE_SHIFT]};
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_stop      = r_stop;
        n_start     = r_start;
        n_run       = r_run;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_low_end   = r_low_end;
        n_mem_end   = r_mem_end;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_wa      = r_pos[BIT_W +: AW];
        ram_wd      = '0;
        ram_re      = 1'b0;
        ram_ra      = r_pos[BIT_W +: AW];
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOW_ZONE_END: n_low_end = i_cfg_data;
                CFG_MEMORY_END:   n_mem_end = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_pos  = r_pos + FRAME_W'(WORD_W);
                if (r_pos[BIT_W +: AW] == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_res = '0;
                case (r_req.opcode)
                    OP_ALLOC: begin
                        n_pos   = zone_lo;
                        n_start = zone_lo;
                        n_stop  = zone_hi;
                        n_run   = '0;
                        if (r_req.page_count == '0 || zone_lo >= zone_hi) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_ALLOC_RD;
                        end
                    end
                    OP_FREE, OP_RESERVE: begin
                        n_pos  = mk_first;
                        n_stop = mk_stop;
                        if (mk_first >= mk_stop) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_MARK_RD;
                        end
                    end
                    OP_TEST: begin
                        n_pos = probe_frame;
                        if (probe_frame >= FRAME_LIMIT) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_TEST_RD;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_ALLOC_RD: begin
                ram_re  = 1'b1;
                n_state = ST_ALLOC_SEG;
            end
            ST_ALLOC_SEG: begin
                if (seg_hit) begin
                    n_res.found        = 1'b1;
                    n_res.base_address = {r_start[FRAME_W-2:0], {PAGE_SHIFT{1'b0}}};
                    n_pos              = r_start;
                    n_stop             = r_start + r_req.page_count;
                    n_state            = ST_MARK_RD;
                end else begin
                    n_pos = seg_next;
                    if (cand == '0) begin
                        n_run = run_sum[FRAME_W-1:0];
                    end else begin
                        n_run   = '0;
                        n_start = seg_next;
                    end
                    if (seg_next >= r_stop) begin
                        n_state = ST_DONE;
                    end else if (cand == '0 || first_used == BIT_W'(WORD_W - 1)) begin
                        n_state = ST_ALLOC_RD;
                    end
                end
            end
            ST_MARK_RD: begin
                ram_re  = 1'b1;
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                ram_we = 1'b1;
                if (r_req.opcode == OP_FREE) begin
                    ram_wd = ram_rd & ~(upper_mask & lower_mask);
                end else begin
                    ram_wd = ram_rd | (upper_mask & lower_mask);
                end
                n_pos = wbase + FRAME_W'(WORD_W);
                if (wbase + FRAME_W'(WORD_W) >= r_stop) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MARK_RD;
                end
            end
            ST_TEST_RD: begin
                ram_re  = 1'b1;
                n_state = ST_TEST_BIT;
            end
            ST_TEST_BIT: begin
                n_res.frame_used = ram_rd[bit_off];
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_low_end   <= LOW_END_RST;
            r_mem_end   <= MEM_END_RST;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_low_end   <= n_low_end;
            r_mem_end   <= n_mem_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stop  <= n_stop;
        r_start <= n_start;
        r_run   <= n_run;
        r_req   <= n_req;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
